>>> hdl/tcf_pkg.sv
`timescale 1ns / 1ps

package tcf_pkg;

    // Widths of the stream words.
    localparam int InDataWidth  = 8;
    localparam int OutDataWidth = 16;
    localparam int OutUserWidth = 1;

    // Connection states, one-hot inside the block.
    typedef enum logic [10:0] {
        ST_CLOSED    = 11'b000_0000_0001,
        ST_LISTEN    = 11'b000_0000_0010,
        ST_SYNSENT   = 11'b000_0000_0100,
        ST_SYNRCVD   = 11'b000_0000_1000,
        ST_ESTAB     = 11'b000_0001_0000,
        ST_FINWAIT1  = 11'b000_0010_0000,
        ST_FINWAIT2  = 11'b000_0100_0000,
        ST_CLOSING   = 11'b000_1000_0000,
        ST_TIMEWAIT  = 11'b001_0000_0000,
        ST_CLOSEWAIT = 11'b010_0000_0000,
        ST_LASTACK   = 11'b100_0000_0000
    } t_conn_state;

    // State codes as they appear on the result stream.
    typedef enum logic [3:0] {
        SC_CLOSED    = 4'd0,
        SC_LISTEN    = 4'd1,
        SC_SYNSENT   = 4'd2,
        SC_SYNRCVD   = 4'd3,
        SC_ESTAB     = 4'd4,
        SC_FINWAIT1  = 4'd5,
        SC_FINWAIT2  = 4'd6,
        SC_CLOSING   = 4'd7,
        SC_TIMEWAIT  = 4'd8,
        SC_CLOSEWAIT = 4'd9,
        SC_LASTACK   = 4'd10
    } t_state_code;

    typedef enum logic [3:0] {
        EV_ACTIVE_OPEN  = 4'd0,
        EV_PASSIVE_OPEN = 4'd1,
        EV_CLOSE        = 4'd2,
        EV_SEND         = 4'd3,
        EV_SYN          = 4'd4,
        EV_SYN_ACK      = 4'd5,
        EV_ACK_SYN      = 4'd6,
        EV_FIN          = 4'd7,
        EV_ACK_FIN      = 4'd8,
        EV_TIMEOUT      = 4'd9,
        EV_DATA         = 4'd10
    } t_event;

    typedef enum logic [3:0] {
        ACT_NONE   = 4'd0,
        ACT_OPEN   = 4'd1,
        ACT_SYN    = 4'd2,
        ACT_SYNACK = 4'd3,
        ACT_ACK    = 4'd4,
        ACT_FIN    = 4'd5,
        ACT_CLOSE  = 4'd6,
        ACT_SEND   = 4'd7,
        ACT_RECV   = 4'd8
    } t_action;

    typedef enum logic [1:0] {
        ROLE_NONE = 2'd0,
        ROLE_RX   = 2'd1,
        ROLE_TX   = 2'd2
    } t_role;

    // One result word.
    typedef struct packed {
        t_state_code next_state;
        t_action     first_action;
        t_action     second_action;
        t_role       conn_role;
        logic        bad_event;
        logic        last_result;
    } t_result;

    // Everything one event produces, handed to the output buffer.
    typedef struct packed {
        t_result first;
        t_result second;
        logic    chain;
    } t_step_out;

    function automatic t_state_code state_code(input t_conn_state s);
        t_state_code c;
        c = SC_CLOSED;
        unique case (s)
            ST_CLOSED:    c = SC_CLOSED;
            ST_LISTEN:    c = SC_LISTEN;
            ST_SYNSENT:   c = SC_SYNSENT;
            ST_SYNRCVD:   c = SC_SYNRCVD;
            ST_ESTAB:     c = SC_ESTAB;
            ST_FINWAIT1:  c = SC_FINWAIT1;
            ST_FINWAIT2:  c = SC_FINWAIT2;
            ST_CLOSING:   c = SC_CLOSING;
            ST_TIMEWAIT:  c = SC_TIMEWAIT;
            ST_CLOSEWAIT: c = SC_CLOSEWAIT;
            ST_LASTACK:   c = SC_LASTACK;
            default:      c = SC_CLOSED;
        endcase
        return c;
    endfunction

endpackage

>>> hdl/tcf_in_reg.sv
`timescale 1ns / 1ps

module tcf_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [3:0] i_req_type,
    input  logic       i_pkt_fin,
    input  logic       i_pkt_eod,
    input  logic       i_take,
    output logic       o_valid,
    output logic [3:0] o_req_type,
    output logic       o_pkt_fin,
    output logic       o_pkt_eod
);

    logic       r_valid;
    logic [3:0] r_req_type;
    logic       r_pkt_fin;
    logic       r_pkt_eod;

    // The register frees up in the same cycle its word is taken.
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req_type <= i_req_type;
            r_pkt_fin  <= i_pkt_fin;
            r_pkt_eod  <= i_pkt_eod;
        end
    end

    assign o_valid    = r_valid;
    assign o_req_type = r_req_type;
    assign o_pkt_fin  = r_pkt_fin;
    assign o_pkt_eod  = r_pkt_eod;

endmodule

>>> hdl/tcf_step.sv
`timescale 1ns / 1ps

module tcf_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  logic [3:0]         i_req_type,
    input  logic               i_pkt_fin,
    input  logic               i_pkt_eod,
    output tcf_pkg::t_step_out o_step
);

    import tcf_pkg::*;

    t_conn_state r_state;
    t_role       r_role;

    t_event      ev;
    t_conn_state nst;
    t_conn_state fst;
    t_action     a1;
    t_action     a2;
    t_role       role;
    t_role       role1;
    t_role       frole;
    logic        ok;
    logic        chain;

    // Event check and transition for the current state.
    always_comb begin
        ev   = t_event'(i_req_type);
        nst  = r_state;
        a1   = ACT_NONE;
        a2   = ACT_NONE;
        role = r_role;
        ok   = 1'b1;

        // Data in ESTABLISHED is mapped by role; no role counts as receiver.
        if (r_state == ST_ESTAB && ev == EV_DATA) begin
            if (r_role == ROLE_TX) begin
                if (i_pkt_fin) ev = EV_FIN;
                else           a1 = ACT_SEND;
            end else begin
                if (i_pkt_eod) ev = EV_CLOSE;
                else           a1 = ACT_RECV;
            end
        end

        unique case (r_state)
            ST_CLOSED: begin
                case (ev)
                    EV_ACTIVE_OPEN: begin
                        nst = ST_SYNSENT; a1 = ACT_OPEN; a2 = ACT_SYN; role = ROLE_RX;
                    end
                    EV_PASSIVE_OPEN: begin
                        nst = ST_LISTEN; a1 = ACT_OPEN; role = ROLE_TX;
                    end
                    default: ok = 1'b0;
                endcase
            end
            ST_LISTEN: begin
                case (ev)
                    EV_SEND:  begin nst = ST_SYNSENT; a1 = ACT_SYN;    end
                    EV_CLOSE: begin nst = ST_CLOSED;  a1 = ACT_CLOSE;  end
                    EV_SYN:   begin nst = ST_SYNRCVD; a1 = ACT_SYNACK; end
                    default:  ok = 1'b0;
                endcase
            end
            ST_SYNSENT: begin
                case (ev)
                    EV_CLOSE:   begin nst = ST_CLOSED;  a1 = ACT_CLOSE; end
                    EV_SYN:     begin nst = ST_SYNRCVD; a1 = ACT_ACK;   end
                    EV_SYN_ACK: begin nst = ST_ESTAB;   a1 = ACT_ACK;   end
                    default:    ok = 1'b0;
                endcase
            end
            ST_SYNRCVD: begin
                case (ev)
                    EV_CLOSE:   begin nst = ST_FINWAIT1; a1 = ACT_FIN;  end
                    EV_ACK_SYN: begin nst = ST_ESTAB;    a1 = ACT_SEND; end
                    default:    ok = 1'b0;
                endcase
            end
            ST_ESTAB: begin
                case (ev)
                    EV_CLOSE: begin nst = ST_FINWAIT1;  a1 = ACT_FIN; end
                    EV_FIN:   begin nst = ST_CLOSEWAIT; a1 = ACT_ACK; end
                    EV_DATA:  nst = ST_ESTAB;
                    default:  ok = 1'b0;
                endcase
            end
            ST_CLOSEWAIT: begin
                if (ev == EV_CLOSE) begin
                    nst = ST_LASTACK; a1 = ACT_FIN;
                end else begin
                    ok = 1'b0;
                end
            end
            ST_LASTACK: begin
                if (ev == EV_ACK_FIN) begin
                    nst = ST_CLOSED; a1 = ACT_CLOSE;
                end else begin
                    ok = 1'b0;
                end
            end
            ST_FINWAIT1: begin
                case (ev)
                    EV_FIN:     begin nst = ST_CLOSING; a1 = ACT_ACK; end
                    EV_ACK_FIN: nst = ST_FINWAIT2;
                    default:    ok = 1'b0;
                endcase
            end
            ST_FINWAIT2: begin
                if (ev == EV_FIN) begin
                    nst = ST_TIMEWAIT; a1 = ACT_ACK;
                end else begin
                    ok = 1'b0;
                end
            end
            ST_TIMEWAIT: begin
                if (ev == EV_TIMEOUT) begin
                    nst = ST_CLOSED; a1 = ACT_CLOSE;
                end else begin
                    ok = 1'b0;
                end
            end
            // CLOSING accepts nothing.
            default: ok = 1'b0;
        endcase
    end

    // An ACK for a FIN that lands in the peer-closed wait state or the linger
    // state runs one step further.
    always_comb begin
        chain = ok && ev == EV_FIN && (nst == ST_CLOSEWAIT || nst == ST_TIMEWAIT);
        role1 = (nst == ST_CLOSED) ? ROLE_NONE : role;
        fst   = nst;
        if (chain) begin
            fst = (nst == ST_CLOSEWAIT) ? ST_LASTACK : ST_CLOSED;
        end
        frole = (fst == ST_CLOSED) ? ROLE_NONE : role1;
    end

    // Result words for the output buffer.
    always_comb begin
        if (!ok) begin
            o_step.first = '{state_code(r_state), ACT_NONE, ACT_NONE, r_role, 1'b1, 1'b1};
        end else begin
            o_step.first = '{state_code(nst), a1, a2, role1, 1'b0, !chain};
        end
        o_step.second = '{state_code(fst), (nst == ST_CLOSEWAIT) ? ACT_FIN : ACT_CLOSE,
                          ACT_NONE, frole, 1'b0, 1'b1};
        o_step.chain  = chain;
    end

    // Connection state; an invalid event leaves it alone.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLOSED;
            r_role  <= ROLE_NONE;
        end else if (i_take && ok) begin
            r_state <= fst;
            r_role  <= frole;
        end
    end

endmodule

>>> hdl/tcf_out_buf.sv
`timescale 1ns / 1ps

module tcf_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  tcf_pkg::t_step_out i_step,
    output logic               o_free,
    output logic               o_valid,
    input  logic               i_ready,
    output tcf_pkg::t_result   o_result
);

    import tcf_pkg::*;

    logic    r_valid;
    logic    r_pend_valid;
    t_result r_data;
    t_result r_pend;

    // A new event may enter when no chained word waits and the output drains.
    assign o_free = !r_pend_valid && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (i_load) begin
            r_valid      <= 1'b1;
            r_pend_valid <= i_step.chain;
        end else if (r_valid && i_ready) begin
            r_valid      <= r_pend_valid;
            r_pend_valid <= 1'b0;
        end
    end

    // Payload: the first word goes out, a chained second word waits behind it.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_step.first;
            r_pend <= i_step.second;
        end else if (r_valid && i_ready && r_pend_valid) begin
            r_data <= r_pend;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_data;

endmodule

>>> hdl/tcp_connection_fsm.sv
`timescale 1ns / 1ps
// An event word accepted from the input stream sits in the input register; once the
// output side has room, its first result word is loaded into the output register,
// from which it can be accepted.
// Throughput: one event word per cycle while the output side has room; an ACK-for-FIN
// event that chains gives two result words and holds the input while the second waits.
// Reset (i_rst_n low, synchronous) empties both registers and returns to CLOSED, no role.

module tcp_connection_fsm (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [3:0] req_type, [4] pkt_fin, [5] pkt_eod, [7:6] zero
    input  logic [tcf_pkg::InDataWidth-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [3:0] next_state, [7:4] first_action, [11:8] second_action,
    // [13:12] conn_role, [15:14] zero
    output logic [tcf_pkg::OutDataWidth-1:0]    m_axis_tdata,
    // [0] bad_event
    output logic [tcf_pkg::OutUserWidth-1:0]    m_axis_tuser,
    output logic                                m_axis_tlast
);

    import tcf_pkg::*;

    logic       in_valid;
    logic [3:0] in_req_type;
    logic       in_pkt_fin;
    logic       in_pkt_eod;
    logic       out_free;
    logic       take;
    t_step_out  step;
    t_result    result;

    // An event leaves the input register when the output side has room.
    assign take = in_valid && out_free;

    tcf_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_req_type (s_axis_tdata[3:0]),
        .i_pkt_fin  (s_axis_tdata[4]),
        .i_pkt_eod  (s_axis_tdata[5]),
        .i_take     (take),
        .o_valid    (in_valid),
        .o_req_type (in_req_type),
        .o_pkt_fin  (in_pkt_fin),
        .o_pkt_eod  (in_pkt_eod)
    );

    tcf_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_req_type (in_req_type),
        .i_pkt_fin  (in_pkt_fin),
        .i_pkt_eod  (in_pkt_eod),
        .o_step     (step)
    );

    tcf_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take),
        .i_step   (step),
        .o_free   (out_free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    // Pack the result word onto the master stream.
    assign m_axis_tdata = {2'b00, result.conn_role, result.second_action,
                           result.first_action, result.next_state};
    assign m_axis_tuser = result.bad_event;
    assign m_axis_tlast = result.last_result;

endmodule

>>> test/tcp_connection_fsm_test.sv
`timescale 1ns / 1ps

module tcp_connection_fsm_test;

    import tcf_pkg::*;

    localparam int ClkHalf      = 4;
    localparam int ResetCycles  = 5;
    localparam int RandomEvents = 600;
    localparam int CalmItems    = 60;    // the tail of the run has no idling
    localparam int HoldCycles   = 48;    // long receiver hold-off that fills the block
    localparam int HoldAfter    = 150;   // result words checked before the hold-off
    localparam int StallLimit   = 2000;  // cycles with no word moving on either side
    localparam int DrainCycles  = 8;

    // Connection state as the predictor tracks it.
    typedef struct packed {
        t_state_code st;
        t_role       role;
    } t_conn;

    // One event word waiting to be sent.
    typedef struct packed {
        logic [3:0] ev;
        logic       fin;
        logic       eod;
    } t_event_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;

    t_event_word pending_events[$];
    t_result     expected_results[$];
    t_conn       plan_conn;     // state seen by the stimulus generator
    t_conn       tracked_conn;  // state advanced on each accepted event word

    logic in_taken = 1'b0;
    int   src_idle = 0;
    int   sink_stall = 0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;
    int   idle_cycles = 0;
    int   events_accepted = 0;
    int   words_checked = 0;
    int   chained_steps = 0;
    int   refused_events = 0;
    int   mismatches = 0;

    tcp_connection_fsm u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(ClkHalf) i_clk = ~i_clk;

    // Next connection state and the one or two result words for one event.
    function automatic int fsm_step(input t_conn now, input logic [3:0] ev_in,
                                    input logic fin, input logic eod,
                                    output t_conn after, output t_result r0,
                                    output t_result r1);
        logic [3:0]  ev;
        t_state_code nst;
        t_action     a1;
        t_action     a2;
        t_role       nrole;
        bit          ok;
        ev = ev_in;
        nst = now.st;
        a1 = ACT_NONE;
        a2 = ACT_NONE;
        nrole = now.role;
        ok = 1'b1;
        r0 = '0;
        r1 = '0;
        after = now;

        // Data in ESTABLISHED becomes a FIN, close, send or receive by role and flags.
        if (now.st == SC_ESTAB && ev == EV_DATA) begin
            if (now.role == ROLE_TX) begin
                if (fin) ev = EV_FIN;
                else a1 = ACT_SEND;
            end else begin
                if (eod) ev = EV_CLOSE;
                else a1 = ACT_RECV;
            end
        end

        case (now.st)
            SC_CLOSED: begin
                if (ev == EV_ACTIVE_OPEN) begin
                    nst = SC_SYNSENT; a1 = ACT_OPEN; a2 = ACT_SYN; nrole = ROLE_RX;
                end else if (ev == EV_PASSIVE_OPEN) begin
                    nst = SC_LISTEN; a1 = ACT_OPEN; nrole = ROLE_TX;
                end else ok = 1'b0;
            end
            SC_LISTEN: begin
                if (ev == EV_SEND) begin nst = SC_SYNSENT; a1 = ACT_SYN; end
                else if (ev == EV_CLOSE) begin nst = SC_CLOSED; a1 = ACT_CLOSE; end
                else if (ev == EV_SYN) begin nst = SC_SYNRCVD; a1 = ACT_SYNACK; end
                else ok = 1'b0;
            end
            SC_SYNSENT: begin
                if (ev == EV_CLOSE) begin nst = SC_CLOSED; a1 = ACT_CLOSE; end
                else if (ev == EV_SYN) begin nst = SC_SYNRCVD; a1 = ACT_ACK; end
                else if (ev == EV_SYN_ACK) begin nst = SC_ESTAB; a1 = ACT_ACK; end
                else ok = 1'b0;
            end
            SC_SYNRCVD: begin
                if (ev == EV_CLOSE) begin nst = SC_FINWAIT1; a1 = ACT_FIN; end
                else if (ev == EV_ACK_SYN) begin nst = SC_ESTAB; a1 = ACT_SEND; end
                else ok = 1'b0;
            end
            SC_ESTAB: begin
                if (ev == EV_CLOSE) begin nst = SC_FINWAIT1; a1 = ACT_FIN; end
                else if (ev == EV_FIN) begin nst = SC_CLOSEWAIT; a1 = ACT_ACK; end
                else if (ev == EV_DATA) nst = SC_ESTAB;
                else ok = 1'b0;
            end
            SC_CLOSEWAIT: begin
                if (ev == EV_CLOSE) begin nst = SC_LASTACK; a1 = ACT_FIN; end
                else ok = 1'b0;
            end
            SC_LASTACK: begin
                if (ev == EV_ACK_FIN) begin nst = SC_CLOSED; a1 = ACT_CLOSE; end
                else ok = 1'b0;
            end
            SC_FINWAIT1: begin
                if (ev == EV_FIN) begin nst = SC_CLOSING; a1 = ACT_ACK; end
                else if (ev == EV_ACK_FIN) nst = SC_FINWAIT2;
                else ok = 1'b0;
            end
            SC_FINWAIT2: begin
                if (ev == EV_FIN) begin nst = SC_TIMEWAIT; a1 = ACT_ACK; end
                else ok = 1'b0;
            end
            SC_TIMEWAIT: begin
                if (ev == EV_TIMEOUT) begin nst = SC_CLOSED; a1 = ACT_CLOSE; end
                else ok = 1'b0;
            end
            default: ok = 1'b0;
        endcase

        // A refused event reports the current state and changes nothing.
        if (!ok) begin
            r0.next_state = now.st;
            r0.first_action = ACT_NONE;
            r0.second_action = ACT_NONE;
            r0.conn_role = now.role;
            r0.bad_event = 1'b1;
            r0.last_result = 1'b1;
            return 1;
        end

        if (nst == SC_CLOSED) nrole = ROLE_NONE;

        r0.next_state = nst;
        r0.first_action = a1;
        r0.second_action = a2;
        r0.conn_role = nrole;
        r0.bad_event = 1'b0;
        r0.last_result = 1'b1;

        // The ACK for a FIN runs on through the peer-closed wait state or the
        // linger state.
        if (ev == EV_FIN && a1 == ACT_ACK && (nst == SC_CLOSEWAIT || nst == SC_TIMEWAIT)) begin
            r0.last_result = 1'b0;
            if (nst == SC_CLOSEWAIT) begin
                nst = SC_LASTACK;
                a1 = ACT_FIN;
            end else begin
                nst = SC_CLOSED;
                a1 = ACT_CLOSE;
                nrole = ROLE_NONE;
            end
            r1.next_state = nst;
            r1.first_action = a1;
            r1.second_action = ACT_NONE;
            r1.conn_role = nrole;
            r1.bad_event = 1'b0;
            r1.last_result = 1'b1;
            after.st = nst;
            after.role = nrole;
            return 2;
        end

        after.st = nst;
        after.role = nrole;
        return 1;
    endfunction

    // An event that the given state accepts, weighted toward going deeper.
    // Packed as {eod, fin, event}.
    function automatic logic [5:0] pick_legal_event(input t_conn c);
        logic [3:0] ev;
        logic       fin;
        logic       eod;
        int         k;
        k = $urandom_range(0, 99);
        fin = 1'($urandom_range(0, 1));
        eod = 1'($urandom_range(0, 1));
        case (c.st)
            SC_CLOSED:    ev = (k < 50) ? EV_ACTIVE_OPEN : EV_PASSIVE_OPEN;
            SC_LISTEN:    ev = (k < 20) ? EV_CLOSE : (k < 50) ? EV_SEND : EV_SYN;
            SC_SYNSENT:   ev = (k < 15) ? EV_CLOSE : (k < 50) ? EV_SYN : EV_SYN_ACK;
            SC_SYNRCVD:   ev = (k < 30) ? EV_CLOSE : EV_ACK_SYN;
            SC_ESTAB: begin
                if (k < 15) ev = EV_CLOSE;
                else if (k < 30) ev = EV_FIN;
                else begin
                    // Keep the flags rare so a connection carries some data.
                    ev = EV_DATA;
                    fin = ($urandom_range(0, 3) == 0);
                    eod = ($urandom_range(0, 3) == 0);
                end
            end
            SC_CLOSEWAIT: ev = EV_CLOSE;
            SC_LASTACK:   ev = EV_ACK_FIN;
            SC_FINWAIT1:  ev = EV_ACK_FIN;
            SC_FINWAIT2:  ev = EV_FIN;
            SC_TIMEWAIT:  ev = EV_TIMEOUT;
            default:      ev = EV_CLOSE;
        endcase
        return {eod, fin, ev};
    endfunction

    // Adds one event word to the send queue and advances the generator's state.
    task automatic queue_event(input logic [3:0] ev, input logic fin, input logic eod);
        t_event_word w;
        t_result     r0;
        t_result     r1;
        t_conn       nxt;
        w.ev = ev;
        w.fin = fin;
        w.eod = eod;
        pending_events.push_back(w);
        void'(fsm_step(plan_conn, ev, fin, eod, nxt, r0, r1));
        plan_conn = nxt;
    endtask

    task automatic check_field(input string what, input logic [3:0] want,
                               input logic [3:0] got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // Event word driver: a new word or an idle burst after each accepted word.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (src_idle > 0) begin
                src_idle <= src_idle - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_events.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (pending_events.size() > CalmItems && $urandom_range(0, 7) == 0) begin
                src_idle <= $urandom_range(0, 3);
                s_axis_tvalid <= 1'b0;
            end else begin
                t_event_word w;
                w = pending_events.pop_front();
                s_axis_tdata <= {2'b00, w.eod, w.fin, w.ev};
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // Result ready: random stall bursts and one long hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && words_checked >= HoldAfter) begin
            hold_done <= 1'b1;
            hold_left <= HoldCycles - 1;
            m_axis_tready <= 1'b0;
        end else if (sink_stall > 0) begin
            sink_stall <= sink_stall - 1;
            m_axis_tready <= 1'b0;
        end else if (pending_events.size() > CalmItems && $urandom_range(0, 5) == 0) begin
            sink_stall <= $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Accepted event words: predict the result words they cause.
    always @(posedge i_clk) begin
        t_result r0;
        t_result r1;
        t_conn   nxt;
        int      n;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
            tracked_conn.st = SC_CLOSED;
            tracked_conn.role = ROLE_NONE;
        end else begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                n = fsm_step(tracked_conn, s_axis_tdata[3:0], s_axis_tdata[4],
                             s_axis_tdata[5], nxt, r0, r1);
                tracked_conn = nxt;
                events_accepted++;
                expected_results.push_back(r0);
                if (r0.bad_event) refused_events++;
                if (n == 2) begin
                    expected_results.push_back(r1);
                    chained_steps++;
                end
            end
        end
    end

    // Accepted result words: compare with the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                $display("%0t: result word with nothing expected, got data 0x%h user %b last %b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end else begin
                want = expected_results.pop_front();
                check_field("next_state", want.next_state, m_axis_tdata[3:0]);
                check_field("first_action", want.first_action, m_axis_tdata[7:4]);
                check_field("second_action", want.second_action, m_axis_tdata[11:8]);
                check_field("conn_role", {2'b00, want.conn_role},
                            {2'b00, m_axis_tdata[13:12]});
                check_field("bad_event", {3'b000, want.bad_event},
                            {3'b000, m_axis_tuser[0]});
                check_field("last_result", {3'b000, want.last_result},
                            {3'b000, m_axis_tlast});
            end
            words_checked++;
        end
    end

    // Watchdog on cycles in which no word moves on either side.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= StallLimit) begin
                $display("timeout: no word moved for %0d cycles, %0d results outstanding",
                         StallLimit, expected_results.size());
                $display("FAIL tcp_connection_fsm");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        logic [5:0] w;
        logic [3:0] ev;
        logic [3:0] lead;
        int         i;

        plan_conn.st = SC_CLOSED;
        plan_conn.role = ROLE_NONE;

        // Directed walk: every transition reachable from reset except the FIN into CLOSING,
        // both roles, data mapping, both chained ACKs and refused events.
        queue_event(4'hF, 1'b1, 1'b1);
        queue_event(EV_PASSIVE_OPEN, 1'b0, 1'b0);
        queue_event(EV_TIMEOUT, 1'b0, 1'b0);
        queue_event(EV_SYN, 1'b0, 1'b0);
        queue_event(EV_ACK_SYN, 1'b0, 1'b0);
        queue_event(EV_DATA, 1'b0, 1'b1);
        queue_event(EV_DATA, 1'b1, 1'b0);
        queue_event(EV_ACK_FIN, 1'b0, 1'b0);
        queue_event(EV_ACTIVE_OPEN, 1'b0, 1'b0);
        queue_event(EV_SYN_ACK, 1'b0, 1'b0);
        queue_event(EV_DATA, 1'b1, 1'b0);
        queue_event(EV_FIN, 1'b0, 1'b0);
        queue_event(EV_ACK_FIN, 1'b0, 1'b0);
        queue_event(EV_ACTIVE_OPEN, 1'b0, 1'b0);
        queue_event(EV_SYN, 1'b0, 1'b0);
        queue_event(EV_CLOSE, 1'b0, 1'b0);
        queue_event(EV_ACK_FIN, 1'b0, 1'b0);
        queue_event(EV_FIN, 1'b1, 1'b1);
        queue_event(EV_PASSIVE_OPEN, 1'b0, 1'b0);
        queue_event(EV_SEND, 1'b0, 1'b0);
        queue_event(EV_CLOSE, 1'b0, 1'b0);
        queue_event(EV_PASSIVE_OPEN, 1'b0, 1'b0);
        queue_event(EV_CLOSE, 1'b0, 1'b0);
        queue_event(EV_ACTIVE_OPEN, 1'b0, 1'b0);
        queue_event(EV_SYN_ACK, 1'b0, 1'b0);
        queue_event(EV_DATA, 1'b0, 1'b1);
        queue_event(4'hB, 1'b0, 1'b1);

        // Random part: mostly legal connection lifetimes, some noise. A FIN in
        // FIN_WAIT_1 would lock the block in CLOSING, so it is kept for the end.
        for (i = 0; i < RandomEvents; i++) begin
            if ($urandom_range(0, 99) < 15) begin
                ev = 4'($urandom_range(0, 15));
                if (plan_conn.st == SC_FINWAIT1 && ev == EV_FIN) ev = EV_ACK_FIN;
                queue_event(ev, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                w = pick_legal_event(plan_conn);
                queue_event(w[3:0], w[4], w[5]);
            end
        end

        // Close out: walk to FIN_WAIT_1, enter CLOSING, then show it refuses the events that follow.
        while (plan_conn.st != SC_FINWAIT1) begin
            case (plan_conn.st)
                SC_CLOSED:    lead = EV_ACTIVE_OPEN;
                SC_LISTEN:    lead = EV_SYN;
                SC_SYNSENT:   lead = EV_SYN_ACK;
                SC_LASTACK:   lead = EV_ACK_FIN;
                SC_FINWAIT2:  lead = EV_FIN;
                SC_TIMEWAIT:  lead = EV_TIMEOUT;
                default:      lead = EV_CLOSE;
            endcase
            queue_event(lead, 1'b0, 1'b0);
        end
        queue_event(EV_FIN, 1'b0, 1'b0);
        queue_event(EV_CLOSE, 1'b0, 1'b0);
        queue_event(EV_TIMEOUT, 1'b0, 1'b0);
        queue_event(EV_DATA, 1'b1, 1'b1);
        queue_event(EV_ACK_FIN, 1'b0, 1'b0);
        queue_event(EV_ACTIVE_OPEN, 1'b0, 1'b0);

        // Synchronous reset, released on a falling edge.
        repeat (ResetCycles) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_events.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        $display("Sent %0d events (%0d refused, %0d with a chained second result),",
                 events_accepted, refused_events, chained_steps);
        $display("checked %0d result words, %0d mismatches.", words_checked, mismatches);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("PASS tcp_connection_fsm");
        end else begin
            $display("FAIL tcp_connection_fsm");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/tcf_pkg.sv
hdl/tcf_in_reg.sv
hdl/tcf_step.sv
hdl/tcf_out_buf.sv
hdl/tcp_connection_fsm.sv
test/tcp_connection_fsm_test.sv
